@@ hw/rtl/lpsnr_pkg.sv @@
package lpsnr_pkg;

    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS = 16;
    localparam int unsigned SSE_BITS = 42;
    localparam int unsigned PIX_BITS = 27;
    localparam int unsigned LOG_FRAC = 24;
    localparam int unsigned LOG_BITS = 32;
    localparam int unsigned DEF_MAX_DIM = 4096;
    localparam int unsigned DEF_SAMPLE_BITS = 8;
    localparam logic [15:0] PEAK_SQ = 16'd65025;
    localparam logic [25:0] DB_PER_LOG2 = 26'd50504453;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_COUNT  = 2'd2,
        REG_FIRST  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
    } log_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [LOG_BITS-1:0] value;
    } log_rsp_t;

endpackage

@@ hw/rtl/lpsnr_log2.sv @@
module lpsnr_log2
    import lpsnr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  log_req_t req,
    output log_rsp_t rsp
);

    // normalize at start, then one squaring per cycle for each fraction bit
    logic [5:0]          exp_reg, exp_next;
    logic [31:0]         man_reg, man_next;
    logic [LOG_FRAC-1:0] frac_reg, frac_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [5:0]          top;
    logic [63:0]         sq;
    logic [63:0]         x1;

    always_comb begin
        x1 = (req.x == 64'd0) ? 64'd1 : req.x;
        top = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (x1[i]) top = 6'(i);
        end
    end

    assign sq = (64'(man_reg) * 64'(man_reg)) >> 30;

    always_comb begin
        exp_next = exp_reg;
        man_next = man_reg;
        frac_next = frac_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            exp_next = top;
            if (top >= 6'd30) man_next = 32'(x1 >> (top - 6'd30));
            else man_next = 32'(x1 << (6'd30 - top));
            frac_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sq[31]) begin
                man_next = 32'(sq >> 1);
                frac_next = {frac_reg[LOG_FRAC-2:0], 1'b1};
            end else begin
                man_next = sq[31:0];
                frac_next = {frac_reg[LOG_FRAC-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(LOG_FRAC - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        exp_reg <= exp_next;
        man_reg <= man_next;
        frac_reg <= frac_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.value = {2'b00, exp_reg, frac_reg};

endmodule

@@ hw/rtl/luma_psnr_meter_unit.sv @@
// Luma PSNR meter. Takes one reference/test luma word per accepted handshake,
// in raster order, and sums squared differences. Pixel words are taken back to
// back while ready is high. At each frame end the block drops ready and runs
// the frame's PSNR through a shared log2 unit that squares one mantissa per
// cycle: two logs in turn, then a multiply stage. Ready stays low through these
// steps (a frame with no error at all skips the logs and the multiply), and
// while the result word waits. At the end of a sequence the mean is found by a
// restoring divider, one quotient bit per cycle, with ready still low. Results leave through an
// output register; the average word follows its frame's word and carries last.
// Configuration is applied at once; zero sizes count as one, sizes above
// MAX_DIM saturate.
module luma_psnr_meter_unit
    import lpsnr_pkg::*;
#(
    parameter int unsigned MAX_DIM = DEF_MAX_DIM,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SAMPLE_BITS-1:0]   s_ref_luma,
    input  logic [SAMPLE_BITS-1:0]   s_test_luma,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [15:0]              m_psnr_db,
    output logic                     m_is_infinite,
    output logic                     m_is_average,
    output logic [16:0]              m_frame_number,
    output logic                     m_last
);

    localparam int unsigned DIM_BITS = $clog2(MAX_DIM + 1);
    localparam int unsigned PP_BITS = PIX_BITS + 16;

    typedef enum logic [8:0] {
        ST_PIX   = 9'b000000001,
        ST_LOGA  = 9'b000000010,
        ST_LOGB  = 9'b000000100,
        ST_MUL   = 9'b000001000,
        ST_FOUT  = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_AOUT  = 9'b001000000,
        ST_WAITA = 9'b010000000,
        ST_WAITB = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [12:0] width_reg, height_reg;
    logic [15:0] count_reg, first_reg;

    logic [SSE_BITS-1:0] sse_reg;
    logic [PIX_BITS-1:0] pix_reg;
    logic [15:0]         frm_reg;
    logic [31:0]         total_reg;
    logic                anyinf_reg;
    logic [16:0]         num_reg;
    logic [LOG_BITS-1:0] la_reg;
    logic [57:0]         prod_reg;
    logic [31:0]         quo_reg, rem_reg;
    logic [5:0]          dcnt_reg;

    logic        ov_reg;
    logic [15:0] o_db_reg;
    logic        o_inf_reg, o_avg_reg, o_last_reg;
    logic [16:0] o_num_reg;

    log_req_t lreq;
    log_rsp_t lrsp;

    lpsnr_log2 u_log (.aclk(aclk), .aresetn(aresetn), .req(lreq), .rsp(lrsp));

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [12:0] v);
        if (v == 13'd0) return DIM_BITS'(1);
        if (32'(v) > MAX_DIM) return DIM_BITS'(MAX_DIM);
        return DIM_BITS'(v);
    endfunction

    logic [PIX_BITS-1:0]    frame_total;
    logic [15:0]            count_eff;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SSE_BITS-1:0]    sse_acc;
    logic [PIX_BITS-1:0]    pix_inc;
    logic [PP_BITS-1:0]     pix_peak;
    logic                   s_fire, m_fire;
    logic [LOG_BITS-1:0]    ldiff;
    logic [15:0]            db_frame;
    logic [32:0]            rem_try;

    assign frame_total = PIX_BITS'(clamp_dim(width_reg)) * PIX_BITS'(clamp_dim(height_reg));
    assign count_eff = (count_reg == 16'd0) ? 16'd1 : count_reg;
    assign diff = (s_ref_luma >= s_test_luma) ? s_ref_luma - s_test_luma
                                              : s_test_luma - s_ref_luma;
    assign sse_acc = sse_reg + SSE_BITS'({{SAMPLE_BITS{1'b0}}, diff}
                                         * {{SAMPLE_BITS{1'b0}}, diff});
    assign pix_inc = pix_reg + PIX_BITS'(1);
    assign pix_peak = PP_BITS'(pix_reg) * PP_BITS'(PEAK_SQ);
    assign s_ready = (state_reg == ST_PIX) && !ov_reg;
    assign s_fire = s_valid && s_ready;
    assign m_fire = ov_reg && m_ready;
    assign ldiff = (la_reg > lrsp.value) ? la_reg - lrsp.value : '0;
    assign db_frame = (prod_reg[57:40] > 18'd65535) ? 16'hFFFF
                                                    : prod_reg[55:40];
    assign rem_try = {rem_reg, quo_reg[31]} - 33'(frm_reg);

    always_comb begin
        lreq.start = 1'b0;
        lreq.x = 64'(sse_reg);
        state_next = state_reg;
        case (state_reg)
            ST_PIX: begin
                if (s_fire && pix_inc >= frame_total) begin
                    if (sse_acc == '0) state_next = ST_FOUT;
                    else state_next = ST_LOGA;
                end
            end
            ST_LOGA: begin
                lreq.start = !lrsp.busy && !lrsp.done && (la_reg == '1);
                lreq.x = 64'(pix_peak);
                if (lrsp.done) state_next = ST_WAITB;
            end
            ST_WAITB: begin
                lreq.start = 1'b1;
                state_next = ST_LOGB;
            end
            ST_LOGB: if (lrsp.done) state_next = ST_MUL;
            ST_MUL: state_next = ST_FOUT;
            ST_FOUT: if (!ov_reg) state_next = ST_WAITA;
            ST_WAITA: begin
                if (frm_reg >= count_eff) state_next = ST_DIV;
                else state_next = ST_PIX;
            end
            ST_DIV: if (dcnt_reg == 6'd32) state_next = ST_AOUT;
            ST_AOUT: if (!ov_reg) state_next = ST_PIX;
            default: state_next = ST_PIX;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_PIX;
            width_reg <= 13'd176;
            height_reg <= 13'd144;
            count_reg <= 16'd1;
            first_reg <= 16'd0;
            sse_reg <= '0;
            pix_reg <= '0;
            frm_reg <= '0;
            total_reg <= '0;
            anyinf_reg <= 1'b0;
            ov_reg <= 1'b0;
            la_reg <= '1;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    REG_WIDTH:  width_reg <= cfg_data[12:0];
                    REG_HEIGHT: height_reg <= cfg_data[12:0];
                    REG_COUNT:  count_reg <= cfg_data;
                    REG_FIRST:  first_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_fire) ov_reg <= 1'b0;
            case (state_reg)
                ST_PIX: begin
                    if (s_fire) begin
                        sse_reg <= sse_acc;
                        pix_reg <= pix_inc;
                        num_reg <= 17'(first_reg) + 17'(frm_reg);
                    end
                end
                ST_LOGA: if (lrsp.done) la_reg <= lrsp.value;
                ST_LOGB: if (lrsp.done) prod_reg <= 58'(ldiff) * 58'(DB_PER_LOG2)
                                                    + (58'(1) << 39);
                ST_FOUT: begin
                    if (!ov_reg) begin
                        ov_reg <= 1'b1;
                        o_avg_reg <= 1'b0;
                        o_last_reg <= 1'b0;
                        o_num_reg <= num_reg;
                        if (sse_reg == '0) begin
                            o_db_reg <= 16'hFFFF;
                            o_inf_reg <= 1'b1;
                            anyinf_reg <= 1'b1;
                        end else begin
                            o_db_reg <= db_frame;
                            o_inf_reg <= 1'b0;
                            total_reg <= total_reg + 32'(db_frame);
                        end
                        frm_reg <= frm_reg + 16'd1;
                        sse_reg <= '0;
                        pix_reg <= '0;
                        la_reg <= '1;
                    end
                end
                ST_WAITA: begin
                    quo_reg <= total_reg + 32'(frm_reg >> 1);
                    rem_reg <= '0;
                    dcnt_reg <= '0;
                end
                ST_DIV: begin
                    if (dcnt_reg != 6'd32) begin
                        if (!rem_try[32]) rem_reg <= rem_try[31:0];
                        else rem_reg <= {rem_reg[30:0], quo_reg[31]};
                        quo_reg <= {quo_reg[30:0], !rem_try[32]};
                        dcnt_reg <= dcnt_reg + 6'd1;
                    end
                end
                ST_AOUT: begin
                    if (!ov_reg) begin
                        ov_reg <= 1'b1;
                        o_avg_reg <= 1'b1;
                        o_last_reg <= 1'b1;
                        o_num_reg <= num_reg;
                        o_inf_reg <= anyinf_reg;
                        if (anyinf_reg || quo_reg > 32'd65535) o_db_reg <= 16'hFFFF;
                        else o_db_reg <= quo_reg[15:0];
                        frm_reg <= '0;
                        total_reg <= '0;
                        anyinf_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid = ov_reg;
    assign m_psnr_db = o_db_reg;
    assign m_is_infinite = o_inf_reg;
    assign m_is_average = o_avg_reg;
    assign m_frame_number = o_num_reg;
    assign m_last = o_last_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_PIX) else $error("ready outside pixel state");
    a_last_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_last == m_is_average) else $error("last without average");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_psnr_db) && $stable(m_frame_number))
        else $error("result word changed while waiting");
`endif

endmodule

@@ test/psnr_result_checker.sv @@
`timescale 1ns / 1ps

module psnr_result_checker
    import lpsnr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [7:0]               s_ref_luma,
    input  logic [7:0]               s_test_luma,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [15:0]              m_psnr_db,
    input  logic                     m_is_infinite,
    input  logic                     m_is_average,
    input  logic [16:0]              m_frame_number,
    input  logic                     m_last,
    output int                       fail_count,
    output int                       words_pending
);

    typedef struct packed {
        logic [15:0] psnr_db;
        logic        is_infinite;
        logic        is_average;
        logic [16:0] frame_number;
        logic        last;
    } psnr_word_t;

    psnr_word_t psnr_words_due[$];

    logic [12:0] width_reg, height_reg;
    logic [15:0] count_reg, first_reg;
    logic [63:0] sse_acc, pix_seen, frames_done, db_total;
    logic        saw_infinite;

    assign words_pending = psnr_words_due.size();

    function automatic logic [63:0] clamp_dim(input logic [12:0] v);
        if (v == 0) return 1;
        if (v > 4096) return 4096;
        return {51'd0, v};
    endfunction

    // log2 in q.24 by repeated squaring of a q1.30 mantissa
    function automatic logic [63:0] log2_q24(input logic [63:0] x);
        int          e;
        logic [63:0] m, frac;
        e = 0;
        frac = 0;
        if (x == 0) x = 1;
        while (e < 63 && (x >> (e + 1)) != 0) e++;
        if (e >= 30) m = x >> (e - 30);
        else m = x << (30 - e);
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(e) << 24) | frac;
    endfunction

    function automatic logic [63:0] frame_psnr(input logic [63:0] pixels, sse);
        logic [63:0] la, lb, l, q;
        la = log2_q24(64'(PEAK_SQ) * pixels);
        lb = log2_q24(sse);
        l = (la > lb) ? la - lb : 0;
        q = (l * 64'(DB_PER_LOG2) + (64'd1 << 39)) >> 40;
        return (q > 65535) ? 64'd65535 : q;
    endfunction

    task automatic measure_pixel(input logic [7:0] r, t);
        logic [63:0] d, num, db, cnt;
        psnr_word_t  w;
        d = (r >= t) ? r - t : t - r;
        sse_acc = sse_acc + d * d;
        pix_seen = pix_seen + 1;
        if (pix_seen < clamp_dim(width_reg) * clamp_dim(height_reg)) return;
        num = first_reg + frames_done;
        w.is_average = 1'b0;
        w.last = 1'b0;
        w.frame_number = num[16:0];
        if (sse_acc == 0) begin
            saw_infinite = 1'b1;
            w.psnr_db = 16'hffff;
            w.is_infinite = 1'b1;
        end else begin
            db = frame_psnr(pix_seen, sse_acc);
            db_total = db_total + db;
            w.psnr_db = db[15:0];
            w.is_infinite = 1'b0;
        end
        psnr_words_due.push_back(w);
        frames_done = frames_done + 1;
        sse_acc = 0;
        pix_seen = 0;
        cnt = (count_reg == 0) ? 1 : count_reg;
        if (frames_done >= cnt) begin
            // sequence mean follows the frame word
            w.is_average = 1'b1;
            w.last = 1'b1;
            if (saw_infinite) begin
                w.psnr_db = 16'hffff;
                w.is_infinite = 1'b1;
            end else begin
                db = (db_total + frames_done / 2) / frames_done;
                w.psnr_db = (db > 65535) ? 16'hffff : db[15:0];
                w.is_infinite = 1'b0;
            end
            psnr_words_due.push_back(w);
            frames_done = 0;
            db_total = 0;
            saw_infinite = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        psnr_word_t exp_w, got_w;
        if (!aresetn) begin
            width_reg = 176;
            height_reg = 144;
            count_reg = 1;
            first_reg = 0;
            sse_acc = 0;
            pix_seen = 0;
            frames_done = 0;
            db_total = 0;
            saw_infinite = 1'b0;
            psnr_words_due.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                got_w = '{m_psnr_db, m_is_infinite, m_is_average, m_frame_number, m_last};
                if (psnr_words_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result word %p", $time, got_w);
                end else begin
                    exp_w = psnr_words_due.pop_front();
                    if (got_w !== exp_w) begin
                        fail_count++;
                        $display("%0t: result mismatch expected %p actual %p",
                                 $time, exp_w, got_w);
                    end
                end
            end
            if (s_valid && s_ready) measure_pixel(s_ref_luma, s_test_luma);
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    REG_WIDTH:  width_reg = cfg_data[12:0];
                    REG_HEIGHT: height_reg = cfg_data[12:0];
                    REG_COUNT:  count_reg = cfg_data;
                    REG_FIRST:  first_reg = cfg_data;
                endcase
            end
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import lpsnr_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 200;   // frame end log work plus divider
    localparam int PIXEL_TARGET = 1200;   // random part, after the directed cases

    typedef enum {PIX_SAME, PIX_NEAR, PIX_RANDOM, PIX_EXTREME} pix_mode_e;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [7:0]               s_ref_luma = '0;
    logic [7:0]               s_test_luma = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [15:0]              m_psnr_db;
    logic                     m_is_infinite;
    logic                     m_is_average;
    logic [16:0]              m_frame_number;
    logic                     m_last;

    int  fail_count, words_pending;
    int  cycle_count = 0;
    int  pixels_sent = 0;
    int  burst_left = 0;
    logic pixel_took = 1'b0;   // a pixel word went in at the last rising edge

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    luma_psnr_meter_unit dut (.*);

    psnr_result_checker checker_i (.*);

    always @(posedge aclk) pixel_took <= s_valid && s_ready;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stalls: the mode steps in turn through four m_ready patterns
    always @(negedge aclk) begin
        int stall_mode;
        stall_mode = (cycle_count / 300) % 4;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // one pixel word; bursts of random length with random gaps between them
    task automatic send_pixel(input logic [7:0] r, t);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid <= 1'b1;
        s_ref_luma <= r;
        s_test_luma <= t;
        do @(negedge aclk); while (!pixel_took);
        burst_left--;
        pixels_sent++;
    endtask

    task automatic send_pixels(input int n, input pix_mode_e mode);
        logic [7:0] r, t;
        int d;
        for (int i = 0; i < n; i++) begin
            r = 8'($urandom_range(0, 255));
            case (mode)
                PIX_SAME: t = r;
                PIX_NEAR: begin
                    d = int'(r) + $urandom_range(0, 6) - 3;
                    t = (d < 0) ? 8'd0 : (d > 255) ? 8'd255 : d[7:0];
                end
                PIX_EXTREME: begin
                    r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    t = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                end
                default: t = 8'($urandom_range(0, 255));
            endcase
            send_pixel(r, t);
        end
    endtask

    // wait until every expected word is out, then let the block settle
    task automatic drain;
        s_valid <= 1'b0;
        burst_left = 0;
        while (words_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(input logic [15:0] w, h, c, f);
        cfg_we <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data <= w;
        @(negedge aclk);
        cfg_index <= REG_HEIGHT;
        cfg_data <= h;
        @(negedge aclk);
        cfg_index <= REG_COUNT;
        cfg_data <= c;
        @(negedge aclk);
        cfg_index <= REG_FIRST;
        cfg_data <= f;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int w, h, c, frames;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single pixel frames: extremes, identical pairs give infinite psnr
        set_config(1, 1, 1, 0);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd128, 8'd127);
        drain();
        // zero sizes count as one, frame numbers run past 16 bits
        set_config(0, 0, 3, 16'hffff);
        send_pixels(6, PIX_NEAR);
        send_pixels(3, PIX_RANDOM);
        drain();
        // zero frame count counts as one, identical pixels give infinite frames
        set_config(2, 1, 0, 16'h0a5a);
        send_pixels(4, PIX_SAME);
        drain();
        // oversize width saturates: the line stays open, then a shrink closes it
        set_config(16'h1fff, 1, 2, 16'h0001);
        send_pixels(200, PIX_NEAR);
        drain();
        set_config(2, 1, 2, 16'h0001);
        send_pixels(3, PIX_NEAR);
        drain();
        // oversize height, huge frame count, then shrink mid-sequence
        set_config(1, 16'h1fff, 16'hffff, 16'h8000);
        send_pixels(200, PIX_RANDOM);
        drain();
        set_config(2, 3, 16'hffff, 16'h7fff);
        send_pixels(12, PIX_RANDOM);
        drain();
        // mid-frame change: frame closes on pixels actually summed
        set_config(4, 4, 2, 16'h0100);
        send_pixels(5, PIX_EXTREME);
        drain();
        set_config(2, 2, 1, 16'h0100);
        send_pixels(1, PIX_RANDOM);
        drain();

        pixels_sent = 0;
        while (pixels_sent < PIXEL_TARGET) begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            h = $urandom_range(1, 4);
            c = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            set_config(16'(w), 16'(h), 16'(c), 16'($urandom_range(0, 65535)));
            frames = $urandom_range(1, 8);
            for (int i = 0; i < frames; i++)
                send_pixels((w == 0 ? 1 : w) * h, pix_mode_e'($urandom_range(0, 3)));
            // sometimes leave a partial frame for the next setting
            if ($urandom_range(0, 3) == 0)
                send_pixels($urandom_range(1, 3), PIX_RANDOM);
            drain();
        end

        drain();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ luma_psnr_meter_unit.f @@
hw/rtl/lpsnr_pkg.sv
hw/rtl/lpsnr_log2.sv
hw/rtl/luma_psnr_meter_unit.sv
test/psnr_result_checker.sv
test/testbench.sv
